// File: hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg - closest point of approach shared definitions
// widths, stage payload types and packing constants for the cpa pipeline
// ----------------------------------------------------------------------------
package cpa_pkg;

    localparam int COORD_WIDTH = 20;                     // input coordinate width
    localparam int NAX         = 3;                      // axes
    localparam int DW          = COORD_WIDTH + 1;        // relative position / velocity
    localparam int PW          = 2 * DW;                 // one axis product
    localparam int SQW         = 2 * COORD_WIDTH + 2;    // sum of three squares
    localparam int DOTW        = SQW + 1;                // signed dot product
    localparam int FRAC_BITS   = 16;
    localparam int NUMW        = SQW + FRAC_BITS;        // dividend
    localparam int TW          = 37;                     // time, unsigned q21.16
    localparam int DISTW       = 42;                     // squared distance
    localparam int TLW         = (TW + 1) / 2;           // low part of time
    localparam int THW         = TW - TLW;               // high part of time
    localparam int CMW         = TW + DW + 2;            // signed component
    localparam int CAW         = TW + 1;                 // component magnitude
    localparam int HLW         = CAW / 2;                // half of magnitude
    localparam int CSW         = 2 * CAW;                // component square
    localparam int ACCW        = CSW + 2;                // sum of component squares
    localparam int DROP        = 2 * FRAC_BITS;          // fraction bits of the sum
    localparam int NFIELD      = 4 * NAX;                // input fields
    localparam int INW         = ((NFIELD * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUTW        = ((TW + DISTW + 7) / 8) * 8;

    typedef logic [NAX-1:0][COORD_WIDTH-1:0] coord_vec_t;
    typedef logic [NAX-1:0][DW-1:0]          vec_t;

    // what travels beside the divider and distance datapath
    typedef struct packed {
        vec_t           p;
        vec_t           v;
        logic [SQW-1:0] psq;
        logic           special;   // no motion or approach already past
        logic           approach;
    } side_t;

endpackage

// File: hdl/cpa_front.sv
// ----------------------------------------------------------------------------
// cpa_front - relative motion and dot products
// four stages: differences, axis products, sums, case decode and dividend
// ----------------------------------------------------------------------------
module cpa_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  cpa_pkg::coord_vec_t        pos_a,
    input  cpa_pkg::coord_vec_t        vel_a,
    input  cpa_pkg::coord_vec_t        pos_b,
    input  cpa_pkg::coord_vec_t        vel_b,
    output logic                       out_valid,
    output cpa_pkg::side_t             side_o,
    output logic [cpa_pkg::NUMW-1:0]   num_o,
    output logic [cpa_pkg::SQW-1:0]    den_o
);

    logic [3:0]                                  vld_reg;
    cpa_pkg::vec_t                               p1_reg, v1_reg, p1_next, v1_next;
    cpa_pkg::vec_t                               p2_reg, v2_reg, p3_reg, v3_reg;
    logic [cpa_pkg::NAX-1:0][cpa_pkg::PW-1:0]    pv_reg, vv_reg, pp_reg;
    logic [cpa_pkg::NAX-1:0][cpa_pkg::PW-1:0]    pv_next, vv_next, pp_next;
    logic [cpa_pkg::SQW-1:0]                     vsq_reg, psq_reg, vsq_next, psq_next;
    logic [cpa_pkg::DOTW-1:0]                    dot_reg, dot_next, ndot;
    cpa_pkg::side_t                              side_reg, side_next;
    logic [cpa_pkg::NUMW-1:0]                    num_reg, num_next;
    logic [cpa_pkg::SQW-1:0]                     den_reg;
    logic                                        no_motion, dot_neg, dot_zero;

    // differences, sign extended by one bit
    always_comb begin
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            p1_next[i] = {pos_b[i][cpa_pkg::COORD_WIDTH-1], pos_b[i]}
                       - {pos_a[i][cpa_pkg::COORD_WIDTH-1], pos_a[i]};
            v1_next[i] = {vel_b[i][cpa_pkg::COORD_WIDTH-1], vel_b[i]}
                       - {vel_a[i][cpa_pkg::COORD_WIDTH-1], vel_a[i]};
        end
    end

    always_comb begin
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            pv_next[i] = cpa_pkg::PW'($signed(p1_reg[i]) * $signed(v1_reg[i]));
            vv_next[i] = cpa_pkg::PW'($signed(v1_reg[i]) * $signed(v1_reg[i]));
            pp_next[i] = cpa_pkg::PW'($signed(p1_reg[i]) * $signed(p1_reg[i]));
        end
    end

    // squares are never negative, the dot product is
    always_comb begin
        vsq_next = '0;
        psq_next = '0;
        dot_next = '0;
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            vsq_next = vsq_next + cpa_pkg::SQW'(vv_reg[i]);
            psq_next = psq_next + cpa_pkg::SQW'(pp_reg[i]);
            dot_next = dot_next + cpa_pkg::DOTW'($signed(pv_reg[i]));
        end
    end

    always_comb begin
        no_motion           = (vsq_reg == '0);
        dot_neg             = dot_reg[cpa_pkg::DOTW-1];
        dot_zero            = (dot_reg == '0);
        ndot                = -dot_reg;
        side_next.p         = p3_reg;
        side_next.v         = v3_reg;
        side_next.psq       = psq_reg;
        side_next.special   = no_motion | !dot_neg;
        side_next.approach  = no_motion | dot_zero | dot_neg;
        num_next            = {ndot[cpa_pkg::SQW-1:0], {cpa_pkg::FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg   <= p1_next;
            v1_reg   <= v1_next;
            pv_reg   <= pv_next;
            vv_reg   <= vv_next;
            pp_reg   <= pp_next;
            p2_reg   <= p1_reg;
            v2_reg   <= v1_reg;
            vsq_reg  <= vsq_next;
            psq_reg  <= psq_next;
            dot_reg  <= dot_next;
            p3_reg   <= p2_reg;
            v3_reg   <= v2_reg;
            side_reg <= side_next;
            num_reg  <= num_next;
            den_reg  <= vsq_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign side_o    = side_reg;
    assign num_o     = num_reg;
    assign den_o     = den_reg;

endmodule

// File: hdl/cpa_div.sv
// ----------------------------------------------------------------------------
// cpa_div - pipelined restoring divider
// one quotient bit per stage, time = dividend / squared relative speed
// ----------------------------------------------------------------------------
module cpa_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  cpa_pkg::side_t             side_i,
    input  logic [cpa_pkg::NUMW-1:0]   num_i,
    input  logic [cpa_pkg::SQW-1:0]    den_i,
    output logic                       out_valid,
    output cpa_pkg::side_t             side_o,
    output logic [cpa_pkg::TW-1:0]     quo_o
);

    logic [cpa_pkg::TW-1:0]       vld_reg;
    cpa_pkg::side_t               side_reg [cpa_pkg::TW];
    logic [cpa_pkg::NUMW-1:0]     num_reg  [cpa_pkg::TW];
    logic [cpa_pkg::SQW-1:0]      den_reg  [cpa_pkg::TW];
    logic [cpa_pkg::SQW-1:0]      rem_reg  [cpa_pkg::TW];
    logic [cpa_pkg::SQW-1:0]      rem_next [cpa_pkg::TW];
    logic [cpa_pkg::TW-1:0]       quo_reg  [cpa_pkg::TW];
    logic [cpa_pkg::TW-1:0]       quo_next [cpa_pkg::TW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[cpa_pkg::TW-2:0], in_valid};
        end
    end

    for (genvar j = 0; j < cpa_pkg::TW; j++) begin : g_stage
        logic [cpa_pkg::SQW-1:0]  src_rem;
        logic [cpa_pkg::NUMW-1:0] src_num;
        logic [cpa_pkg::SQW-1:0]  src_den;
        logic [cpa_pkg::TW-1:0]   src_quo;
        cpa_pkg::side_t           src_side;
        logic [cpa_pkg::SQW:0]    trial;
        logic [cpa_pkg::SQW:0]    diff;
        logic                     take;

        if (j == 0) begin : g_first
            // top dividend bits start the remainder
            assign src_rem  = {{(cpa_pkg::SQW - cpa_pkg::NUMW + cpa_pkg::TW){1'b0}},
                               num_i[cpa_pkg::NUMW-1:cpa_pkg::TW]};
            assign src_num  = num_i;
            assign src_den  = den_i;
            assign src_quo  = '0;
            assign src_side = side_i;
        end else begin : g_rest
            assign src_rem  = rem_reg[j-1];
            assign src_num  = num_reg[j-1];
            assign src_den  = den_reg[j-1];
            assign src_quo  = quo_reg[j-1];
            assign src_side = side_reg[j-1];
        end

        assign trial = {src_rem, src_num[cpa_pkg::TW-1-j]};
        assign diff  = trial - {1'b0, src_den};
        assign take  = (trial >= {1'b0, src_den});

        always_comb begin
            rem_next[j] = take ? diff[cpa_pkg::SQW-1:0] : trial[cpa_pkg::SQW-1:0];
            quo_next[j] = {src_quo[cpa_pkg::TW-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next[j];
                quo_reg[j]  <= quo_next[j];
                num_reg[j]  <= src_num;
                den_reg[j]  <= src_den;
                side_reg[j] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[cpa_pkg::TW-1];
    assign side_o    = side_reg[cpa_pkg::TW-1];
    assign quo_o     = quo_reg[cpa_pkg::TW-1];

endmodule

// File: hdl/cpa_dist.sv
// ----------------------------------------------------------------------------
// cpa_dist - squared distance at the approach time
// six stages: v*t halves, component, magnitude, partial squares, square,
// sum with result select
// ----------------------------------------------------------------------------
module cpa_dist (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  cpa_pkg::side_t              side_i,
    input  logic [cpa_pkg::TW-1:0]      time_i,
    output logic                        out_valid,
    output logic [cpa_pkg::TW-1:0]      time_o,
    output logic [cpa_pkg::DISTW-1:0]   dist_o,
    output logic                        approach_o
);

    localparam int PAW = cpa_pkg::DW + cpa_pkg::TLW + 1;
    localparam int PBW = cpa_pkg::DW + cpa_pkg::THW + 1;

    logic [5:0]                                        vld_reg;
    cpa_pkg::side_t                                    s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic [cpa_pkg::TW-1:0]                            t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic [cpa_pkg::NAX-1:0][PAW-1:0]                  pa_reg, pa_next;
    logic [cpa_pkg::NAX-1:0][PBW-1:0]                  pb_reg, pb_next;
    logic [cpa_pkg::NAX-1:0][cpa_pkg::CMW-1:0]         comp_reg, comp_next;
    logic [cpa_pkg::NAX-1:0][cpa_pkg::CAW-1:0]         mag_reg, mag_next;
    logic [cpa_pkg::NAX-1:0][2*cpa_pkg::HLW-1:0]       hh_reg, hl_reg, ll_reg;
    logic [cpa_pkg::NAX-1:0][2*cpa_pkg::HLW-1:0]       hh_next, hl_next, ll_next;
    logic [cpa_pkg::NAX-1:0][cpa_pkg::CSW-1:0]         sq_reg, sq_next;
    logic [cpa_pkg::ACCW-1:0]                          total;
    logic [cpa_pkg::TW-1:0]                            time_reg, time_next;
    logic [cpa_pkg::DISTW-1:0]                         dist_reg, dist_next;
    logic                                              appr_reg;

    // velocity times time, split in two narrow products
    always_comb begin
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            pa_next[i] = PAW'($signed(side_i.v[i])
                       * $signed({1'b0, time_i[cpa_pkg::TLW-1:0]}));
            pb_next[i] = PBW'($signed(side_i.v[i])
                       * $signed({1'b0, time_i[cpa_pkg::TW-1:cpa_pkg::TLW]}));
        end
    end

    // p*2^16 + v*t
    always_comb begin
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            comp_next[i] = (cpa_pkg::CMW'($signed(s1_reg.p[i])) <<< cpa_pkg::FRAC_BITS)
                         + cpa_pkg::CMW'($signed(pa_reg[i]))
                         + (cpa_pkg::CMW'($signed(pb_reg[i])) <<< cpa_pkg::TLW);
        end
    end

    always_comb begin
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            mag_next[i] = comp_reg[i][cpa_pkg::CMW-1]
                        ? cpa_pkg::CAW'(-comp_reg[i]) : cpa_pkg::CAW'(comp_reg[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            hh_next[i] = mag_reg[i][cpa_pkg::CAW-1:cpa_pkg::HLW]
                       * mag_reg[i][cpa_pkg::CAW-1:cpa_pkg::HLW];
            hl_next[i] = mag_reg[i][cpa_pkg::CAW-1:cpa_pkg::HLW]
                       * mag_reg[i][cpa_pkg::HLW-1:0];
            ll_next[i] = mag_reg[i][cpa_pkg::HLW-1:0] * mag_reg[i][cpa_pkg::HLW-1:0];
        end
    end

    // cross term counted twice, hence one more bit of shift
    always_comb begin
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            sq_next[i] = (cpa_pkg::CSW'(hh_reg[i]) << (2 * cpa_pkg::HLW))
                       + (cpa_pkg::CSW'(hl_reg[i]) << (cpa_pkg::HLW + 1))
                       + cpa_pkg::CSW'(ll_reg[i]);
        end
    end

    always_comb begin
        total = '0;
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            total = total + cpa_pkg::ACCW'(sq_reg[i]);
        end
        if (s5_reg.special) begin
            time_next = '0;
            dist_next = cpa_pkg::DISTW'(s5_reg.psq);
        end else begin
            time_next = t5_reg;
            if (|total[cpa_pkg::ACCW-1:cpa_pkg::DROP+cpa_pkg::DISTW]) begin
                dist_next = '1;
            end else begin
                dist_next = total[cpa_pkg::DROP+cpa_pkg::DISTW-1:cpa_pkg::DROP];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            s1_reg   <= side_i;
            t1_reg   <= time_i;
            comp_reg <= comp_next;
            s2_reg   <= s1_reg;
            t2_reg   <= t1_reg;
            mag_reg  <= mag_next;
            s3_reg   <= s2_reg;
            t3_reg   <= t2_reg;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            s4_reg   <= s3_reg;
            t4_reg   <= t3_reg;
            sq_reg   <= sq_next;
            s5_reg   <= s4_reg;
            t5_reg   <= t4_reg;
            time_reg <= time_next;
            dist_reg <= dist_next;
            appr_reg <= s5_reg.approach;
        end
    end

    assign out_valid  = vld_reg[5];
    assign time_o     = time_reg;
    assign dist_o     = dist_reg;
    assign approach_o = appr_reg;

endmodule

// File: hdl/closest_approach_time_distance.sv
// ----------------------------------------------------------------------------
// closest_approach_time_distance - closest point of approach of two bodies
// time and squared gap at closest approach for bodies at constant velocity
// ----------------------------------------------------------------------------
//
// channel   direction  carries
// s_axis    in         positions and velocities of bodies a and b
// m_axis    out        approach time, squared distance, approaching flag
//
// one item in and one result out per cycle while the result is not stalled; the pipeline
// is the 37 stage divider, one quotient bit per stage, plus
// four front and six distance stages
// reset clears only the valid bits; no state survives between items
// a stalled result holds the whole pipeline; nothing is lost or repeated
// ----------------------------------------------------------------------------
module closest_approach_time_distance (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pos_a_x, pos_a_y, pos_a_z, vel_a_x, vel_a_y, vel_a_z,
    // pos_b_x, pos_b_y, pos_b_z, vel_b_x, vel_b_y, vel_b_z
    input  logic [cpa_pkg::INW-1:0]     s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // time_ahead, distance_sq, zero pad
    output logic [cpa_pkg::OUTW-1:0]    m_axis_tdata,
    // approaching
    output logic                        m_axis_tuser
);

    logic                           en;
    cpa_pkg::coord_vec_t            pos_a, vel_a, pos_b, vel_b;
    logic                           front_valid, div_valid;
    cpa_pkg::side_t                 front_side, div_side;
    logic [cpa_pkg::NUMW-1:0]       front_num;
    logic [cpa_pkg::SQW-1:0]        front_den;
    logic [cpa_pkg::TW-1:0]         quo, time_ahead;
    logic [cpa_pkg::DISTW-1:0]      distance_sq;

    // pipeline moves whenever the output register is empty or being taken
    assign en            = m_axis_tready | ~m_axis_tvalid;
    assign s_axis_tready = en;

    // unpack the twelve coordinates, lowest field first
    always_comb begin
        for (int i = 0; i < cpa_pkg::NAX; i++) begin
            pos_a[i] = s_axis_tdata[i * cpa_pkg::COORD_WIDTH +: cpa_pkg::COORD_WIDTH];
            vel_a[i] = s_axis_tdata[(cpa_pkg::NAX + i) * cpa_pkg::COORD_WIDTH
                                    +: cpa_pkg::COORD_WIDTH];
            pos_b[i] = s_axis_tdata[(2 * cpa_pkg::NAX + i) * cpa_pkg::COORD_WIDTH
                                    +: cpa_pkg::COORD_WIDTH];
            vel_b[i] = s_axis_tdata[(3 * cpa_pkg::NAX + i) * cpa_pkg::COORD_WIDTH
                                    +: cpa_pkg::COORD_WIDTH];
        end
    end

    // relative motion, dot products, special case decode
    cpa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .pos_a     (pos_a),
        .vel_a     (vel_a),
        .pos_b     (pos_b),
        .vel_b     (vel_b),
        .out_valid (front_valid),
        .side_o    (front_side),
        .num_o     (front_num),
        .den_o     (front_den)
    );

    // approach time in q21.16, truncated
    cpa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .side_i    (front_side),
        .num_i     (front_num),
        .den_i     (front_den),
        .out_valid (div_valid),
        .side_o    (div_side),
        .quo_o     (quo)
    );

    // squared gap at that time and the output register
    cpa_dist u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (div_valid),
        .side_i     (div_side),
        .time_i     (quo),
        .out_valid  (m_axis_tvalid),
        .time_o     (time_ahead),
        .dist_o     (distance_sq),
        .approach_o (m_axis_tuser)
    );

    assign m_axis_tdata = {{(cpa_pkg::OUTW - cpa_pkg::TW - cpa_pkg::DISTW){1'b0}},
                           distance_sq, time_ahead};

endmodule

// File: hdl/cpa_checker.sv
// ----------------------------------------------------------------------------
// cpa_port_checker - port level checks for the closest approach block
// watches handshake, flow control and result consistency
// ----------------------------------------------------------------------------
module cpa_port_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [cpa_pkg::INW-1:0]     s_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [cpa_pkg::OUTW-1:0]    m_axis_tdata,
    input logic                        m_axis_tuser
);

    // no result straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // input taken whenever the output register can move
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // a past approach reports zero time
    a_past_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[cpa_pkg::TW-1:0] == '0)
        else $error("past approach with nonzero time");

endmodule

bind closest_approach_time_distance cpa_port_checker u_cpa_checker (.*);
